### hdl/seir_pkg.sv
// shared types, codes and constants of the screen edge input router
package seir_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned SIZE_BITS      = 15;
  localparam int unsigned CFG_IDX_BITS   = 3;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [2:0] FN_MOVE     = 3'd0;
  localparam logic [2:0] FN_BUTTON   = 3'd1;
  localparam logic [2:0] FN_KEY_DOWN = 3'd2;
  localparam logic [2:0] FN_KEY_UP   = 3'd3;
  localparam logic [2:0] FN_WHEEL    = 3'd4;
  localparam logic [2:0] FN_LEAVE    = 3'd5;
  localparam logic [2:0] FN_FORCE    = 3'd6;

  localparam logic [CFG_IDX_BITS-1:0] REG_SERVER_W = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SERVER_H = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIENT_W = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIENT_H = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_LAYOUT   = 3'd4;

  localparam logic [1:0] LAYOUT_RIGHT = 2'd0;
  localparam logic [1:0] LAYOUT_LEFT  = 2'd1;
  localparam logic [1:0] LAYOUT_ABOVE = 2'd2;
  localparam logic [1:0] LAYOUT_BELOW = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MOVE,
    OP_BUTTON,
    OP_KEY,
    OP_WHEEL,
    OP_LEAVE,
    OP_FORCE
  } op_e;

  typedef enum logic [1:0] {
    PUR_ENTRY,
    PUR_MOVE_X,
    PUR_MOVE_Y,
    PUR_RET
  } pur_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_RET,
    ST_DONE
  } st_e;

  typedef struct packed {
    op_e  op;
    logic left_press;
  } cmd_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0] sw;
    logic [SIZE_BITS-1:0] sh;
    logic [SIZE_BITS-1:0] cw;
    logic [SIZE_BITS-1:0] ch;
    logic [1:0]           layout;
  } cfg_t;

endpackage

### hdl/seir_if.sv
// handshake channel interfaces of the screen edge input router
interface seir_in_if #(parameter int unsigned COORD_BITS = seir_pkg::COORD_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   func;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic [2:0]                   button_id;
  logic                         button_pressed;
  modport source (output valid, func, pos_x, pos_y, button_id, button_pressed, input ready);
  modport sink (input valid, func, pos_x, pos_y, button_id, button_pressed, output ready);
endinterface

interface seir_out_if #(parameter int unsigned COORD_BITS = seir_pkg::COORD_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic                         consumed;
  logic                         forward_valid;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic                         warp_valid;
  logic signed [COORD_BITS-1:0] warp_x;
  logic signed [COORD_BITS-1:0] warp_y;
  logic                         entered;
  logic                         remote_active;
  logic                         keyboard_remote;
  logic                         release_keys;
  logic                         release_buttons;
  modport source (output valid, consumed, forward_valid, out_x, out_y, warp_valid, warp_x,
                  warp_y, entered, remote_active, keyboard_remote, release_keys,
                  release_buttons, input ready);
  modport sink (input valid, consumed, forward_valid, out_x, out_y, warp_valid, warp_x,
                warp_y, entered, remote_active, keyboard_remote, release_keys,
                release_buttons, output ready);
endinterface

interface seir_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [seir_pkg::CFG_IDX_BITS-1:0]     index;
  logic [seir_pkg::SIZE_BITS-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/seir_front.sv
// front end: accepts input words, classifies them and queues commands
module seir_front #(
  parameter int unsigned COORD_BITS = seir_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  seir_in_if.sink                      in_i,
  input  logic                         configured_i,
  output logic                         head_vld_o,
  output seir_pkg::cmd_t               head_o,
  output logic signed [COORD_BITS-1:0] head_x_o,
  output logic signed [COORD_BITS-1:0] head_y_o,
  input  logic                         pop_i
);

  localparam int unsigned QD = seir_pkg::QUEUE_DEPTH;
  localparam int unsigned PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int unsigned NW = $clog2(QD + 1);

  seir_pkg::cmd_t              q_cmd [QD];
  logic signed [COORD_BITS-1:0] q_x  [QD];
  logic signed [COORD_BITS-1:0] q_y  [QD];
  logic [PW-1:0]               wr_q, rd_q;
  logic [NW-1:0]               cnt_q;
  seir_pkg::cmd_t              cls;
  logic                        push;

  always_comb begin
    cls.left_press = (in_i.button_id == 3'd0) && in_i.button_pressed;
    case (in_i.func)
      seir_pkg::FN_MOVE:     cls.op = configured_i ? seir_pkg::OP_MOVE : seir_pkg::OP_NONE;
      seir_pkg::FN_BUTTON:   cls.op = configured_i ? seir_pkg::OP_BUTTON : seir_pkg::OP_NONE;
      seir_pkg::FN_KEY_DOWN: cls.op = configured_i ? seir_pkg::OP_KEY : seir_pkg::OP_NONE;
      seir_pkg::FN_KEY_UP:   cls.op = configured_i ? seir_pkg::OP_KEY : seir_pkg::OP_NONE;
      seir_pkg::FN_WHEEL:    cls.op = configured_i ? seir_pkg::OP_WHEEL : seir_pkg::OP_NONE;
      seir_pkg::FN_LEAVE:    cls.op = seir_pkg::OP_LEAVE;
      seir_pkg::FN_FORCE:    cls.op = seir_pkg::OP_FORCE;
      default:               cls.op = seir_pkg::OP_NONE;
    endcase
  end

  assign in_i.ready = (cnt_q != NW'(QD));
  assign push       = in_i.valid && in_i.ready;
  assign head_vld_o = (cnt_q != '0);
  assign head_o     = q_cmd[rd_q];
  assign head_x_o   = q_x[rd_q];
  assign head_y_o   = q_y[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_cmd[wr_q] <= cls;
      q_x[wr_q]   <= in_i.pos_x;
      q_y[wr_q]   <= in_i.pos_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(QD - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(QD - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### hdl/seir_div.sv
// serial signed by unsigned divider, one quotient bit per cycle
module seir_div #(
  parameter int unsigned DW = seir_pkg::COORD_BITS_DEF + 17
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [DW-1:0]              dividend_i,
  input  logic [seir_pkg::SIZE_BITS-1:0]    divisor_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic signed [DW-1:0]              quo_o,
  output logic signed [seir_pkg::SIZE_BITS:0] rem_o
);

  localparam int unsigned SB   = seir_pkg::SIZE_BITS;
  localparam int unsigned CNTW = $clog2(DW + 1);

  logic [DW-1:0]   mag_q;
  logic [SB-1:0]   rem_q;
  logic [CNTW-1:0] cnt_q;
  logic            neg_q, busy_q, done_q;
  logic [SB:0]     trial, diff;
  logic            take;

  assign trial = {rem_q, mag_q[DW-1]};
  assign take  = (trial >= {1'b0, divisor_i});
  assign diff  = take ? trial - {1'b0, divisor_i} : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DW-1];
      mag_q <= dividend_i[DW-1] ? -dividend_i : dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      mag_q <= {mag_q[DW-2:0], take};
      rem_q <= diff[SB-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(mag_q) : $signed(mag_q);
  assign rem_o  = neg_q ? -$signed({1'b0, rem_q}) : $signed({1'b0, rem_q});

endmodule

### hdl/seir_back.sv
// back end: routing state, scaling sequencer and output register
module seir_back #(
  parameter int unsigned COORD_BITS = seir_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  seir_pkg::cfg_t               cfg_i,
  input  logic                         clr_i,
  input  logic                         head_vld_i,
  input  seir_pkg::cmd_t               head_i,
  input  logic signed [COORD_BITS-1:0] head_x_i,
  input  logic signed [COORD_BITS-1:0] head_y_i,
  output logic                         pop_o,
  seir_out_if.source                   out_o
);

  localparam int unsigned W    = COORD_BITS;
  localparam int unsigned SB   = seir_pkg::SIZE_BITS;
  localparam int unsigned CURW = (W > 16) ? W : 16;
  localparam int unsigned MAW  = CURW + 1;
  localparam int unsigned DW   = CURW + 17;
  localparam int unsigned CMPW = CURW + 2;
  localparam logic signed [DW-1:0] QMAX = (DW'(1) << (W - 1)) - DW'(1);
  localparam logic signed [DW-1:0] QMIN = ~QMAX;

  seir_pkg::st_e  st_q, st_d;
  seir_pkg::pur_e pur_q, pur_d;
  logic                  remote_q, remote_d, keys_q, keys_d;
  logic signed [CURW-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [SB:0]    rem_x_q, rem_x_d, rem_y_q, rem_y_d, add_q, add_d;
  logic signed [W-1:0]   py_q, py_d;
  logic signed [MAW-1:0] mul_a_q, mul_a_d;
  logic [SB-1:0]         mul_b_q, mul_b_d, dvs_q, dvs_d;
  logic signed [DW-1:0]  prod_q, prod_d;

  logic                res_cons_q, res_cons_d, res_fwd_q, res_fwd_d, res_wv_q, res_wv_d;
  logic                res_ent_q, res_ent_d, res_relk_q, res_relk_d, res_relb_q, res_relb_d;
  logic signed [W-1:0] res_ox_q, res_ox_d, res_oy_q, res_oy_d;
  logic signed [W-1:0] res_wx_q, res_wx_d, res_wy_q, res_wy_d;

  logic                o_vld_q, o_vld_d;
  logic                o_cons_q, o_fwd_q, o_wv_q, o_ent_q, o_rem_q, o_keys_q, o_relk_q, o_relb_q;
  logic signed [W-1:0] o_ox_q, o_oy_q, o_wx_q, o_wy_q;
  logic                load_out;

  logic                   div_start, div_busy, div_done;
  logic signed [DW-1:0]   div_quo;
  logic signed [SB:0]     div_rem;

  logic [SB-1:0]          half_sw, half_sh;
  logic signed [CMPW-1:0] hx_c, hy_c, swm1, shm1, cwm1, chm1, cx_c, newc_c;
  logic                   at_edge, back;
  logic signed [DW:0]     sum, hi_c, lim;
  logic signed [CURW-1:0] newc, cur_sel;
  logic [SB-1:0]          c_sel;
  logic signed [DW-1:0]   rhi, rlim;
  logic signed [W-1:0]    ret_v, ent_v;
  logic [SB-1:0]          r_c, r_s;
  logic signed [CURW-1:0] r_cur;

  seir_div #(.DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q + DW'(add_q)),
    .divisor_i  (dvs_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  assign div_start = (st_q == seir_pkg::ST_DIV_GO);
  assign half_sw   = {1'b0, cfg_i.sw[SB-1:1]};
  assign half_sh   = {1'b0, cfg_i.sh[SB-1:1]};

  // edge tests and clamps
  always_comb begin
    hx_c   = CMPW'(head_x_i);
    hy_c   = CMPW'(head_y_i);
    swm1   = $signed(CMPW'(cfg_i.sw)) - CMPW'(1);
    shm1   = $signed(CMPW'(cfg_i.sh)) - CMPW'(1);
    cwm1   = $signed(CMPW'(cfg_i.cw)) - CMPW'(1);
    chm1   = $signed(CMPW'(cfg_i.ch)) - CMPW'(1);
    case (cfg_i.layout)
      seir_pkg::LAYOUT_RIGHT: at_edge = (hx_c >= swm1);
      seir_pkg::LAYOUT_LEFT:  at_edge = (hx_c <= 0);
      seir_pkg::LAYOUT_ABOVE: at_edge = (hy_c <= 0);
      default:                at_edge = (hy_c >= shm1);
    endcase

    cur_sel = (pur_q == seir_pkg::PUR_MOVE_X) ? cur_x_q : cur_y_q;
    c_sel   = (pur_q == seir_pkg::PUR_MOVE_X) ? cfg_i.cw : cfg_i.ch;
    sum     = (DW + 1)'(cur_sel) + (DW + 1)'(div_quo);
    hi_c    = $signed((DW + 1)'(c_sel)) - (DW + 1)'(1);
    lim     = (sum > hi_c) ? hi_c : sum;
    newc    = (lim < 0) ? '0 : CURW'(lim);

    cx_c    = CMPW'(cur_x_q);
    newc_c  = CMPW'(newc);
    case (cfg_i.layout)
      seir_pkg::LAYOUT_RIGHT: back = (cx_c <= 0);
      seir_pkg::LAYOUT_LEFT:  back = (cx_c >= cwm1);
      seir_pkg::LAYOUT_ABOVE: back = (newc_c >= chm1);
      default:                back = (newc_c <= 0);
    endcase

    rhi   = $signed(DW'(mul_b_q)) - DW'(1);
    rlim  = (div_quo > rhi) ? rhi : div_quo;
    ret_v = (rlim < 0) ? '0 : W'(rlim);

    if (div_quo > QMAX) begin
      ent_v = W'(QMAX);
    end else if (div_quo < QMIN) begin
      ent_v = W'(QMIN);
    end else begin
      ent_v = W'(div_quo);
    end

    if (cfg_i.layout == seir_pkg::LAYOUT_RIGHT || cfg_i.layout == seir_pkg::LAYOUT_LEFT) begin
      r_c   = cfg_i.ch;
      r_s   = cfg_i.sh;
      r_cur = cur_y_q;
    end else begin
      r_c   = cfg_i.cw;
      r_s   = cfg_i.sw;
      r_cur = cur_x_q;
    end
  end

  always_comb begin
    st_d       = st_q;
    pur_d      = pur_q;
    remote_d   = remote_q;
    keys_d     = keys_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    rem_x_d    = rem_x_q;
    rem_y_d    = rem_y_q;
    add_d      = add_q;
    py_d       = py_q;
    mul_a_d    = mul_a_q;
    mul_b_d    = mul_b_q;
    dvs_d      = dvs_q;
    prod_d     = prod_q;
    res_cons_d = res_cons_q;
    res_fwd_d  = res_fwd_q;
    res_ox_d   = res_ox_q;
    res_oy_d   = res_oy_q;
    res_wv_d   = res_wv_q;
    res_wx_d   = res_wx_q;
    res_wy_d   = res_wy_q;
    res_ent_d  = res_ent_q;
    res_relk_d = res_relk_q;
    res_relb_d = res_relb_q;
    pop_o      = 1'b0;
    load_out   = 1'b0;
    o_vld_d    = o_vld_q && !out_o.ready;

    case (st_q)
      seir_pkg::ST_IDLE: begin
        if (head_vld_i) begin
          pop_o      = 1'b1;
          py_d       = head_y_i;
          res_cons_d = 1'b0;
          res_fwd_d  = 1'b0;
          res_ox_d   = '0;
          res_oy_d   = '0;
          res_wv_d   = 1'b0;
          res_wx_d   = '0;
          res_wy_d   = '0;
          res_ent_d  = 1'b0;
          res_relk_d = 1'b0;
          res_relb_d = 1'b0;
          st_d       = seir_pkg::ST_DONE;
          case (head_i.op)
            seir_pkg::OP_MOVE: begin
              add_d = '0;
              if (remote_q) begin
                mul_a_d = MAW'(head_x_i) - $signed(MAW'(half_sw));
                mul_b_d = cfg_i.cw;
                dvs_d   = cfg_i.sw;
                add_d   = rem_x_q;
                pur_d   = seir_pkg::PUR_MOVE_X;
                st_d    = seir_pkg::ST_MUL;
              end else if (at_edge) begin
                if (cfg_i.layout == seir_pkg::LAYOUT_RIGHT ||
                    cfg_i.layout == seir_pkg::LAYOUT_LEFT) begin
                  mul_a_d = MAW'(head_y_i);
                  mul_b_d = cfg_i.ch;
                  dvs_d   = cfg_i.sh;
                end else begin
                  mul_a_d = MAW'(head_x_i);
                  mul_b_d = cfg_i.cw;
                  dvs_d   = cfg_i.sw;
                end
                pur_d = seir_pkg::PUR_ENTRY;
                st_d  = seir_pkg::ST_MUL;
              end
            end
            seir_pkg::OP_BUTTON: begin
              if (remote_q) begin
                keys_d     = keys_q | head_i.left_press;
                res_cons_d = 1'b1;
                res_fwd_d  = 1'b1;
                res_ox_d   = W'(cur_x_q);
                res_oy_d   = W'(cur_y_q);
              end
            end
            seir_pkg::OP_KEY: begin
              res_cons_d = remote_q && keys_q;
              res_fwd_d  = remote_q && keys_q;
            end
            seir_pkg::OP_WHEEL: begin
              res_cons_d = remote_q;
              res_fwd_d  = remote_q;
            end
            seir_pkg::OP_LEAVE: begin
              if (remote_q) begin
                st_d = seir_pkg::ST_RET;
              end
            end
            seir_pkg::OP_FORCE: begin
              keys_d = 1'b0;
              if (remote_q) begin
                remote_d   = 1'b0;
                res_relk_d = 1'b1;
              end
            end
            default: begin
              st_d = seir_pkg::ST_DONE;
            end
          endcase
        end
      end

      seir_pkg::ST_MUL: begin
        prod_d = mul_a_q * $signed({1'b0, mul_b_q});
        st_d   = seir_pkg::ST_DIV_GO;
      end

      seir_pkg::ST_DIV_GO: begin
        st_d = seir_pkg::ST_DIV_WAIT;
      end

      seir_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          case (pur_q)
            seir_pkg::PUR_ENTRY: begin
              remote_d = 1'b1;
              keys_d   = 1'b0;
              rem_x_d  = '0;
              rem_y_d  = '0;
              case (cfg_i.layout)
                seir_pkg::LAYOUT_RIGHT: begin
                  cur_x_d = '0;
                  cur_y_d = CURW'(ent_v);
                end
                seir_pkg::LAYOUT_LEFT: begin
                  cur_x_d = CURW'(cwm1);
                  cur_y_d = CURW'(ent_v);
                end
                seir_pkg::LAYOUT_ABOVE: begin
                  cur_x_d = CURW'(ent_v);
                  cur_y_d = CURW'(chm1);
                end
                default: begin
                  cur_x_d = CURW'(ent_v);
                  cur_y_d = '0;
                end
              endcase
              res_cons_d = 1'b1;
              res_ox_d   = W'(cur_x_d);
              res_oy_d   = W'(cur_y_d);
              res_wv_d   = 1'b1;
              res_wx_d   = W'(half_sw);
              res_wy_d   = W'(half_sh);
              res_ent_d  = 1'b1;
              res_relk_d = 1'b1;
              res_relb_d = 1'b1;
              st_d       = seir_pkg::ST_DONE;
            end
            seir_pkg::PUR_MOVE_X: begin
              cur_x_d = newc;
              rem_x_d = div_rem;
              mul_a_d = MAW'(py_q) - $signed(MAW'(half_sh));
              mul_b_d = cfg_i.ch;
              dvs_d   = cfg_i.sh;
              add_d   = rem_y_q;
              pur_d   = seir_pkg::PUR_MOVE_Y;
              st_d    = seir_pkg::ST_MUL;
            end
            seir_pkg::PUR_MOVE_Y: begin
              cur_y_d    = newc;
              rem_y_d    = div_rem;
              res_cons_d = 1'b1;
              if (back) begin
                st_d = seir_pkg::ST_RET;
              end else begin
                res_wv_d  = 1'b1;
                res_wx_d  = W'(half_sw);
                res_wy_d  = W'(half_sh);
                res_fwd_d = 1'b1;
                res_ox_d  = W'(cur_x_q);
                res_oy_d  = W'(newc);
                st_d      = seir_pkg::ST_DONE;
              end
            end
            default: begin
              if (cfg_i.layout == seir_pkg::LAYOUT_RIGHT ||
                  cfg_i.layout == seir_pkg::LAYOUT_LEFT) begin
                res_wy_d = ret_v;
              end else begin
                res_wx_d = ret_v;
              end
              st_d = seir_pkg::ST_DONE;
            end
          endcase
        end
      end

      seir_pkg::ST_RET: begin
        remote_d   = 1'b0;
        keys_d     = 1'b0;
        res_wv_d   = 1'b1;
        res_relk_d = 1'b1;
        case (cfg_i.layout)
          seir_pkg::LAYOUT_RIGHT: res_wx_d = W'(cfg_i.sw) - W'(2);
          seir_pkg::LAYOUT_LEFT:  res_wx_d = W'(1);
          seir_pkg::LAYOUT_ABOVE: res_wy_d = W'(1);
          default:                res_wy_d = W'(cfg_i.sh) - W'(2);
        endcase
        if (r_c == '0) begin
          if (cfg_i.layout == seir_pkg::LAYOUT_RIGHT || cfg_i.layout == seir_pkg::LAYOUT_LEFT) begin
            res_wy_d = W'(r_s >> 1);
          end else begin
            res_wx_d = W'(r_s >> 1);
          end
          st_d = seir_pkg::ST_DONE;
        end else begin
          mul_a_d = MAW'(r_cur);
          mul_b_d = r_s;
          dvs_d   = r_c;
          add_d   = '0;
          pur_d   = seir_pkg::PUR_RET;
          st_d    = seir_pkg::ST_MUL;
        end
      end

      seir_pkg::ST_DONE: begin
        if (!o_vld_q || out_o.ready) begin
          load_out = 1'b1;
          o_vld_d  = 1'b1;
          st_d     = seir_pkg::ST_IDLE;
        end
      end

      default: begin
        st_d = seir_pkg::ST_IDLE;
      end
    endcase

    // layout change drops routing
    if (clr_i) begin
      remote_d = 1'b0;
      keys_d   = 1'b0;
      cur_x_d  = '1;
      cur_y_d  = '1;
      rem_x_d  = '0;
      rem_y_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= seir_pkg::ST_IDLE;
      remote_q <= 1'b0;
      keys_q   <= 1'b0;
      cur_x_q  <= '1;
      cur_y_q  <= '1;
      rem_x_q  <= '0;
      rem_y_q  <= '0;
      o_vld_q  <= 1'b0;
    end else begin
      st_q     <= st_d;
      remote_q <= remote_d;
      keys_q   <= keys_d;
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      rem_x_q  <= rem_x_d;
      rem_y_q  <= rem_y_d;
      o_vld_q  <= o_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pur_q      <= pur_d;
    add_q      <= add_d;
    py_q       <= py_d;
    mul_a_q    <= mul_a_d;
    mul_b_q    <= mul_b_d;
    dvs_q      <= dvs_d;
    prod_q     <= prod_d;
    res_cons_q <= res_cons_d;
    res_fwd_q  <= res_fwd_d;
    res_ox_q   <= res_ox_d;
    res_oy_q   <= res_oy_d;
    res_wv_q   <= res_wv_d;
    res_wx_q   <= res_wx_d;
    res_wy_q   <= res_wy_d;
    res_ent_q  <= res_ent_d;
    res_relk_q <= res_relk_d;
    res_relb_q <= res_relb_d;
    if (load_out) begin
      o_cons_q <= res_cons_q;
      o_fwd_q  <= res_fwd_q;
      o_ox_q   <= res_ox_q;
      o_oy_q   <= res_oy_q;
      o_wv_q   <= res_wv_q;
      o_wx_q   <= res_wx_q;
      o_wy_q   <= res_wy_q;
      o_ent_q  <= res_ent_q;
      o_rem_q  <= remote_q;
      o_keys_q <= keys_q;
      o_relk_q <= res_relk_q;
      o_relb_q <= res_relb_q;
    end
  end

  assign out_o.valid           = o_vld_q;
  assign out_o.consumed        = o_cons_q;
  assign out_o.forward_valid   = o_fwd_q;
  assign out_o.out_x           = o_ox_q;
  assign out_o.out_y           = o_oy_q;
  assign out_o.warp_valid      = o_wv_q;
  assign out_o.warp_x          = o_wx_q;
  assign out_o.warp_y          = o_wy_q;
  assign out_o.entered         = o_ent_q;
  assign out_o.remote_active   = o_rem_q;
  assign out_o.keyboard_remote = o_keys_q;
  assign out_o.release_keys    = o_relk_q;
  assign out_o.release_buttons = o_relb_q;

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_keys_in_remote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    keys_q |-> remote_q)
    else $error("keyboard routed remote while pointer is local");

  a_clr_local: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_i |=> (!remote_q && !keys_q))
    else $error("layout change did not drop routing");

  a_enter_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && o_ent_q) |-> (o_cons_q && o_rem_q && o_wv_q))
    else $error("entry word without consume, remote or warp");

endmodule

### hdl/screen_edge_input_router_top.sv
// top level of the screen edge input router
// Events enter through a two-word queue and are handled one at a time by a
// sequencer that shares one multiplier and one serial divider producing a
// quotient bit per cycle, so the cost of a word is set by the number of
// divisions it needs, each on a D-bit dividend with D = max(COORD_BITS, 16) + 17
// (33 by default): buttons, keys, wheel, leave without return and force local
// need no division, a crossing move one division, a remote move two, a remote
// move that hits the return edge three, and a cursor leave in remote mode one.
// The result register lets the next word start while a result waits to be
// taken. Configuration writes are taken every cycle; a layout write that
// changes the layout drops routing to local mode.
module screen_edge_input_router_top #(
  parameter int unsigned COORD_BITS = seir_pkg::COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  seir_cfg_if.sink    cfg_i,
  seir_in_if.sink     in_i,
  seir_out_if.source  out_o
);

  seir_pkg::cfg_t               cfg_q;
  logic                         cfg_wr, clr;
  logic                         configured;
  logic                         head_vld, pop;
  seir_pkg::cmd_t               head;
  logic signed [COORD_BITS-1:0] head_x, head_y;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;
  assign clr         = cfg_wr && (cfg_i.index == seir_pkg::REG_LAYOUT) &&
                       (cfg_i.data[1:0] != cfg_q.layout);
  assign configured  = (cfg_q.sw != '0) && (cfg_q.sh != '0) &&
                       (cfg_q.cw != '0) && (cfg_q.ch != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_i.index)
        seir_pkg::REG_SERVER_W: cfg_q.sw     <= cfg_i.data;
        seir_pkg::REG_SERVER_H: cfg_q.sh     <= cfg_i.data;
        seir_pkg::REG_CLIENT_W: cfg_q.cw     <= cfg_i.data;
        seir_pkg::REG_CLIENT_H: cfg_q.ch     <= cfg_i.data;
        seir_pkg::REG_LAYOUT:   cfg_q.layout <= cfg_i.data[1:0];
        default: begin
        end
      endcase
    end
  end

  seir_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .configured_i (configured),
    .head_vld_o   (head_vld),
    .head_o       (head),
    .head_x_o     (head_x),
    .head_y_o     (head_y),
    .pop_i        (pop)
  );

  seir_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .clr_i      (clr),
    .head_vld_i (head_vld),
    .head_i     (head),
    .head_x_i   (head_x),
    .head_y_i   (head_y),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule
